// File: sv/cbfq_pkg.sv
// ----------------------------------------------------------------------------
// cbfq_pkg
// shared sizes, entry layout, status codes and scan control for the
// cyclic best-first queue
// ----------------------------------------------------------------------------
package cbfq_pkg;

    // store depth and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // one stored node
    typedef struct packed {
        logic signed [15:0] contour;
        logic signed [31:0] prio;
        logic        [15:0] handle;
        logic        [31:0] order;
    } t_entry;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic start;   // clear accumulators
        logic pass2;   // 0 contour pass, 1 priority pass
        logic dvld;    // read data of this cycle belongs to the pass
    } t_scan_ctl;

endpackage

// File: sv/cbfq_store.sv
// ----------------------------------------------------------------------------
// cbfq_store
// node memory with one write and one registered read port, valid flags
// and lowest free slot search
// ----------------------------------------------------------------------------
module cbfq_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cbfq_pkg::ADDR_W-1:0]   i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [cbfq_pkg::ADDR_W-1:0]   i_wr_addr,
    input  cbfq_pkg::t_entry              i_wr_entry,
    input  logic                          i_clr_en,
    input  logic [cbfq_pkg::ADDR_W-1:0]   i_clr_addr,
    output cbfq_pkg::t_entry              o_rd_entry,
    output logic                          o_rd_valid,
    output logic [cbfq_pkg::ADDR_W-1:0]   o_free_slot,
    output logic                          o_full
);

    cbfq_pkg::t_entry                  r_mem [cbfq_pkg::CAPACITY];
    cbfq_pkg::t_entry                  r_rd_entry;
    logic                              r_rd_valid;
    logic [cbfq_pkg::CAPACITY-1:0]     r_valid;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
    end

    // occupancy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
        end
    end

    // lowest free slot
    always_comb begin
        o_free_slot = '0;
        for (int i = cbfq_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_free_slot = cbfq_pkg::ADDR_W'(i);
            end
        end
    end

    assign o_full     = &r_valid;
    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

// File: sv/cbfq_scan.sv
// ----------------------------------------------------------------------------
// cbfq_scan
// shared compare unit: takes one stored entry per cycle, first pass finds
// the target contour, second pass finds the best node in that contour
// ----------------------------------------------------------------------------
module cbfq_scan (
    input  logic                          i_clk,
    input  cbfq_pkg::t_scan_ctl           i_ctl,
    input  cbfq_pkg::t_entry              i_entry,
    input  logic                          i_entry_valid,
    input  logic [cbfq_pkg::ADDR_W-1:0]   i_idx,
    input  logic signed [15:0]            i_cur_contour,
    input  logic [31:0]                   i_push_seq,
    output logic signed [15:0]            o_target,
    output logic [cbfq_pkg::ADDR_W-1:0]   o_best_idx
);

    logic                              r_any;
    logic signed [15:0]                r_c_min;
    logic                              r_above;
    logic signed [15:0]                r_c_above;
    logic                              r_found;
    logic signed [31:0]                r_best_prio;
    logic [31:0]                       r_best_age;
    logic [cbfq_pkg::ADDR_W-1:0]       r_best_idx;
    logic [31:0]                       age;
    logic                              take;
    logic                              use_entry;

    assign o_target   = r_above ? r_c_above : r_c_min;
    assign o_best_idx = r_best_idx;
    assign use_entry  = i_ctl.dvld && i_entry_valid;
    assign age        = i_push_seq - i_entry.order;

    // better node in the target contour: lower priority, older on ties
    always_comb begin
        take = 1'b0;
        if (i_entry.contour == o_target) begin
            if (!r_found || (i_entry.prio < r_best_prio)) begin
                take = 1'b1;
            end else if ((i_entry.prio == r_best_prio) && (age > r_best_age)) begin
                take = 1'b1;
            end
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_any   <= 1'b0;
            r_above <= 1'b0;
            r_found <= 1'b0;
        end else if (use_entry && !i_ctl.pass2) begin
            r_any <= 1'b1;
            if (!r_any || (i_entry.contour < r_c_min)) begin
                r_c_min <= i_entry.contour;
            end
            if ((i_entry.contour > i_cur_contour) &&
                (!r_above || (i_entry.contour < r_c_above))) begin
                r_c_above <= i_entry.contour;
                r_above   <= 1'b1;
            end
        end else if (use_entry && i_ctl.pass2 && take) begin
            r_found     <= 1'b1;
            r_best_prio <= i_entry.prio;
            r_best_age  <= age;
            r_best_idx  <= i_idx;
        end
    end

endmodule

// File: sv/cyclic_best_first_queue_top.sv
// ----------------------------------------------------------------------------
// cyclic_best_first_queue_top
// Priority store for branch-and-bound nodes grouped by signed contour. A pop
// from a non-empty store sweeps the single read port of the node memory
// twice, once to find the next contour above the current one (wrapping to
// the smallest), once to find that contour's least priority node, oldest on
// ties. A pop from an empty store skips both sweeps. One request is worked
// on at a time; a finished result waits in the output register while the
// next request is taken.
// ----------------------------------------------------------------------------
module cyclic_best_first_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // contour_id[15:0], priority_req[47:16], handle[63:48]
    input  logic        i_s_tuser,   // action[0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // out_handle[15:0], out_contour[31:16],
                                     // out_priority[63:32], stored_count[70:64], zero[71]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUSH  = 7'b0000010,
        S_SCAN1 = 7'b0000100,
        S_SCAN2 = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_TAKE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                              r_state, n_state;
    logic [cbfq_pkg::CNT_W-1:0]          r_count;
    logic signed [15:0]                  r_cur;
    logic [31:0]                         r_seq;
    logic [cbfq_pkg::CNT_W-1:0]          r_cnt;
    logic                                r_dvld;
    logic [cbfq_pkg::ADDR_W-1:0]         r_didx;
    logic                                r_m_valid;

    logic                                r_in_action;
    logic signed [15:0]                  r_in_contour;
    logic signed [31:0]                  r_in_prio;
    logic [15:0]                         r_in_handle;

    cbfq_pkg::t_status                   r_res_status;
    logic [15:0]                         r_res_handle;
    logic [15:0]                         r_res_contour;
    logic [31:0]                         r_res_prio;
    cbfq_pkg::t_status                   r_m_status;
    logic [15:0]                         r_m_handle;
    logic [15:0]                         r_m_contour;
    logic [31:0]                         r_m_prio;
    logic [6:0]                          r_m_count;

    logic                                in_req;
    logic                                out_free;
    logic                                scanning;
    logic                                pass_done;
    cbfq_pkg::t_scan_ctl                 scan_ctl;
    cbfq_pkg::t_entry                    wr_entry;
    cbfq_pkg::t_entry                    rd_entry;
    logic                                rd_valid;
    logic [cbfq_pkg::ADDR_W-1:0]         rd_addr;
    logic [cbfq_pkg::ADDR_W-1:0]         free_slot;
    logic                                full;
    logic                                wr_en;
    logic                                clr_en;
    logic signed [15:0]                  target;
    logic [cbfq_pkg::ADDR_W-1:0]         best_idx;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_req     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;
    assign scanning   = (r_state == S_SCAN1) || (r_state == S_SCAN2);
    assign pass_done  = (r_cnt == cbfq_pkg::CNT_W'(cbfq_pkg::CAPACITY)) && !r_dvld;

    // store access
    assign wr_en    = (r_state == S_PUSH) && !full;
    assign clr_en   = (r_state == S_TAKE);
    assign rd_addr  = (r_state == S_FETCH) ? best_idx : r_cnt[cbfq_pkg::ADDR_W-1:0];
    assign wr_entry = '{contour: r_in_contour, prio: r_in_prio,
                        handle: r_in_handle, order: r_seq};

    // compare unit control
    assign scan_ctl = '{start: (r_state == S_IDLE), pass2: (r_state == S_SCAN2),
                        dvld: (r_dvld && scanning)};

    cbfq_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (rd_addr),
        .i_wr_en     (wr_en),
        .i_wr_addr   (free_slot),
        .i_wr_entry  (wr_entry),
        .i_clr_en    (clr_en),
        .i_clr_addr  (best_idx),
        .o_rd_entry  (rd_entry),
        .o_rd_valid  (rd_valid),
        .o_free_slot (free_slot),
        .o_full      (full)
    );

    cbfq_scan u_scan (
        .i_clk         (i_clk),
        .i_ctl         (scan_ctl),
        .i_entry       (rd_entry),
        .i_entry_valid (rd_valid),
        .i_idx         (r_didx),
        .i_cur_contour (r_cur),
        .i_push_seq    (r_seq),
        .o_target      (target),
        .o_best_idx    (best_idx)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    if (!i_s_tuser) begin
                        n_state = S_PUSH;
                    end else if (r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN1;
                    end
                end
            end
            S_PUSH:  n_state = S_DONE;
            S_SCAN1: if (pass_done) n_state = S_SCAN2;
            S_SCAN2: if (pass_done) n_state = S_FETCH;
            S_FETCH: n_state = S_TAKE;
            S_TAKE:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cur     <= '0;
            r_seq     <= '0;
            r_cnt     <= '0;
            r_dvld    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_seq   <= r_seq + 32'd1;
                r_count <= r_count + cbfq_pkg::CNT_W'(1);
            end
            if (clr_en) begin
                r_cur   <= target;
                r_count <= r_count - cbfq_pkg::CNT_W'(1);
            end
            // sweep address counter
            if (scanning && !pass_done) begin
                if (r_cnt != cbfq_pkg::CNT_W'(cbfq_pkg::CAPACITY)) begin
                    r_cnt  <= r_cnt + cbfq_pkg::CNT_W'(1);
                    r_dvld <= 1'b1;
                end else begin
                    r_dvld <= 1'b0;
                end
            end else begin
                r_cnt  <= '0;
                r_dvld <= 1'b0;
            end
            // output register handshake
            if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // request capture, result building and output payload
    always_ff @(posedge i_clk) begin
        r_didx <= r_cnt[cbfq_pkg::ADDR_W-1:0];
        if (in_req) begin
            r_in_action   <= i_s_tuser;
            r_in_contour  <= i_s_tdata[15:0];
            r_in_prio     <= i_s_tdata[47:16];
            r_in_handle   <= i_s_tdata[63:48];
            r_res_status  <= i_s_tuser ? cbfq_pkg::ST_EMPTY : cbfq_pkg::ST_OK;
            r_res_handle  <= '0;
            r_res_contour <= '0;
            r_res_prio    <= '0;
        end
        if ((r_state == S_PUSH) && !r_in_action) begin
            r_res_status <= full ? cbfq_pkg::ST_FULL : cbfq_pkg::ST_OK;
        end
        if (r_state == S_TAKE) begin
            r_res_status  <= cbfq_pkg::ST_OK;
            r_res_handle  <= rd_entry.handle;
            r_res_contour <= rd_entry.contour;
            r_res_prio    <= rd_entry.prio;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_m_status  <= r_res_status;
            r_m_handle  <= r_res_handle;
            r_m_contour <= r_res_contour;
            r_m_prio    <= r_res_prio;
            r_m_count   <= 7'(r_count);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {1'b0, r_m_count, r_m_prio, r_m_contour, r_m_handle};

endmodule
